@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the compass heading block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define CHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked property that stays live through reset.
`define CHD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHD_ASSERT(lbl, clk, rstn, prop, msg)
`define CHD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/chd_pkg.sv @@
// Constants and the arctangent table for the compass heading CORDIC.
`timescale 1ns / 1ps

package chd_pkg;

    // Angle accumulator: degrees with this many fraction bits.
    localparam int ZFRAC = 20;
    localparam int ZW = 32;

    // Raw axis words and the fixed prescale (a left shift by 12).
    localparam int RAW_W = 16;
    localparam int PRESCALE_SHIFT = 12;
    // Sign-extended axis width: two bits extra, so that negating -32768 fits.
    localparam int AXIS_W = RAW_W + 2;
    // CORDIC x/y width: prescaled value plus room for the CORDIC gain.
    localparam int CW = AXIS_W + PRESCALE_SHIFT + 2;

    localparam int TABLE_LEN = 24;

    // Fraction bits of the heading and the declination. The 17-bit field
    // widths below are sized for this value.
    localparam int ANGLE_FRAC_BITS = 8;

    // Declination register.
    localparam int DEC_W = 17;
    localparam logic signed [DEC_W-1:0] DEC_RESET = -17'sd98;

    // Heading output field and stream widths.
    localparam int HEAD_W = 17;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // 180 degrees in the accumulator format.
    localparam logic signed [ZW-1:0] Z_180 = 32'sd188743680;

    // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest.
    localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

endpackage

@@ rtl/core/compass_heading_atan2.sv @@
// Top level of the compass heading block: pipelined CORDIC atan2 plus declination.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block turns one magnetometer sample into a compass heading.
// The slave channel carries the raw X word in s_tdata[15:0] and the raw Y
// word in s_tdata[31:16], both 16-bit two's complement. The master channel
// returns the heading in m_tdata[16:0], degrees with 8 fraction bits,
// wrapped into 0 to 360 degrees. Exactly one result leaves for every
// input transfer, in order.
// The declination is written through cfg_wr_en / cfg_wr_data at any edge
// where cfg_wr_en is high; it should only change while no sample is in flight.
// Values beyond +/-180 degrees are saturated before use.
// From the input transfer to m_tvalid a sample passes one input stage, one
// stage per CORDIC iteration, a rounding stage, a declination add stage and
// a wrap stage. Throughput is one sample per cycle until the pipeline fills.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up while the receiver stalls and
// s_tready only drops once every stage holds a sample. Synchronous reset
// (aresetn low) empties the pipeline and returns the declination to its
// reset value of -98 (about -0.383 degrees).
module compass_heading_atan2 #(
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Declination register write port.
    input  logic                              cfg_wr_en,
    input  logic [chd_pkg::DEC_W-1:0]         cfg_wr_data,
    // Sample input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [chd_pkg::S_TDATA_W-1:0]     s_tdata,   // x_raw_word, y_raw_word
    // Heading output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chd_pkg::M_TDATA_W-1:0]     m_tdata    // heading_degrees, zero pad
);

    localparam int NSTG = (CORDIC_STAGES > chd_pkg::TABLE_LEN) ?
                          chd_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int CW   = chd_pkg::CW;
    localparam int ZW   = chd_pkg::ZW;
    localparam int AW   = chd_pkg::AXIS_W;
    localparam int DROP = chd_pkg::ZFRAC - chd_pkg::ANGLE_FRAC_BITS;
    // Heading arithmetic width: covers +/-720 degrees and the declination field.
    localparam int HW   = chd_pkg::ANGLE_FRAC_BITS + 14;

    localparam logic signed [ZW-1:0] ROUND_BIAS = ZW'(64'sd1 <<< (DROP - 1));
    localparam logic signed [HW-1:0] HALF_A = HW'(64'sd180 <<< chd_pkg::ANGLE_FRAC_BITS);
    localparam logic signed [HW-1:0] FULL_A = HW'(64'sd360 <<< chd_pkg::ANGLE_FRAC_BITS);

    // Stage registers of the CORDIC section: index 0 is the input stage.
    logic signed [CW-1:0] x_reg    [NSTG+1];
    logic signed [CW-1:0] y_reg    [NSTG+1];
    logic signed [ZW-1:0] z_reg    [NSTG+1];
    logic                 zero_reg [NSTG+1];
    logic                 vld_reg  [NSTG+1];
    logic                 en       [NSTG+1];

    logic signed [chd_pkg::DEC_W-1:0] dec_reg;
    logic signed [HW-1:0]             dec_sat_reg;
    logic signed [HW-1:0]             dec_ext;
    logic signed [HW-1:0]             dec_sat_next;

    logic                 rnd_valid_reg;
    logic signed [HW-1:0] rnd_ang_reg;
    logic                 sum_valid_reg;
    logic signed [HW-1:0] sum_reg;
    logic                 out_valid_reg;
    logic signed [HW-1:0] out_h_reg;

    logic rnd_en;
    logic sum_en;
    logic out_en;

    // Input conversion.
    logic signed [AW-1:0] x_in;
    logic signed [AW-1:0] y_in;
    logic signed [AW-1:0] x_rot;
    logic signed [AW-1:0] y_rot;
    logic signed [ZW-1:0] z_start;
    logic                 zero_in;

    // Rounding and wrap.
    logic signed [ZW-1:0] ang_biased;
    logic signed [ZW-1:0] ang_shifted;
    logic signed [HW-1:0] h_minus;
    logic signed [HW-1:0] h_plus;
    logic signed [HW-1:0] h_next;

    // Handshake chain: a stage loads when it is empty or the next one moves.
    assign out_en = !out_valid_reg || m_tready;
    assign sum_en = !sum_valid_reg || out_en;
    assign rnd_en = !rnd_valid_reg || sum_en;
    assign en[NSTG] = !vld_reg[NSTG] || rnd_en;

    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign s_tready = en[0];

    // Declination register and its saturated copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg <= chd_pkg::DEC_RESET;
        end else if (cfg_wr_en) begin
            dec_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        dec_ext = {{(HW - chd_pkg::DEC_W){dec_reg[chd_pkg::DEC_W-1]}}, dec_reg};
        if (dec_ext > HALF_A) begin
            dec_sat_next = HALF_A;
        end else if (dec_ext < -HALF_A) begin
            dec_sat_next = -HALF_A;
        end else begin
            dec_sat_next = dec_ext;
        end
    end

    always_ff @(posedge aclk) begin
        dec_sat_reg <= dec_sat_next;
    end

    // Input stage: sign conversion, turn by 180 degrees for negative X,
    // prescale by 4096.
    always_comb begin
        x_in    = {{(AW - chd_pkg::RAW_W){s_tdata[15]}}, s_tdata[15:0]};
        y_in    = {{(AW - chd_pkg::RAW_W){s_tdata[31]}}, s_tdata[31:16]};
        zero_in = (s_tdata[15:0] == '0) && (s_tdata[31:16] == '0);
        if (s_tdata[15]) begin
            x_rot   = -x_in;
            y_rot   = -y_in;
            z_start = s_tdata[31] ? -chd_pkg::Z_180 : chd_pkg::Z_180;
        end else begin
            x_rot   = x_in;
            y_rot   = y_in;
            z_start = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en[0]) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0] && s_tvalid) begin
            x_reg[0]    <= {{(CW - AW - chd_pkg::PRESCALE_SHIFT){x_rot[AW-1]}},
                            x_rot, {chd_pkg::PRESCALE_SHIFT{1'b0}}};
            y_reg[0]    <= {{(CW - AW - chd_pkg::PRESCALE_SHIFT){y_rot[AW-1]}},
                            y_rot, {chd_pkg::PRESCALE_SHIFT{1'b0}}};
            z_reg[0]    <= z_start;
            zero_reg[0] <= zero_in;
        end
    end

    // One vectoring CORDIC iteration per stage.
    for (genvar i = 0; i < NSTG; i++) begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic                 rot_pos;

        always_comb begin
            xs      = x_reg[i] >>> i;
            ys      = y_reg[i] >>> i;
            rot_pos = (y_reg[i] > 0);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en[i+1]) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i+1] && vld_reg[i]) begin
                if (rot_pos) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + chd_pkg::ATAN_TABLE[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - chd_pkg::ATAN_TABLE[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Rounding stage: half up to the output fraction; a zero vector gives 0.
    always_comb begin
        ang_biased  = z_reg[NSTG] + ROUND_BIAS;
        ang_shifted = ang_biased >>> DROP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (rnd_en) begin
            rnd_valid_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_en && vld_reg[NSTG]) begin
            rnd_ang_reg <= zero_reg[NSTG] ? '0 : HW'(ang_shifted);
        end
    end

    // Declination add stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_en) begin
            sum_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en && rnd_valid_reg) begin
            sum_reg <= rnd_ang_reg + dec_sat_reg;
        end
    end

    // Wrap stage: both corrections are formed in parallel, then selected
    // and clamped to 0..360 degrees.
    always_comb begin
        h_minus = sum_reg - FULL_A;
        h_plus  = sum_reg + FULL_A;
        if (sum_reg > FULL_A) begin
            h_next = h_minus;
        end else if (sum_reg < 0) begin
            h_next = (h_plus < 0) ? '0 : h_plus;
        end else begin
            h_next = sum_reg;
        end
        if (h_next > FULL_A) begin
            h_next = FULL_A;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && sum_valid_reg) begin
            out_h_reg <= h_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(chd_pkg::M_TDATA_W - chd_pkg::HEAD_W){1'b0}},
                       out_h_reg[chd_pkg::HEAD_W-1:0]};

    // A cycle of reset leaves the output channel empty.
    `CHD_ASSERT_RST(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    // The input only stalls when the whole pipeline is full behind a stalled output.
    `CHD_ASSERT(a_stall_source, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    // A delivered heading always lies within 0 to 360 degrees.
    `CHD_ASSERT(a_heading_range, aclk, aresetn, m_tvalid |-> (out_h_reg >= 0 && out_h_reg <= FULL_A), "heading out of range")

endmodule

@@ sim/compass_heading_atan2_test.sv @@
// Self-checking testbench for the compass heading block, with a scoreboard class.
`timescale 1ns / 1ps

// The testbench sends raw magnetometer samples into compass_heading_atan2 and
// checks every heading that comes back. A scoreboard class keeps its own
// CORDIC prediction and a queue of expected headings in transfer order.
// The run has a short directed part under the reset declination. Then come
// eight random phases. Each phase writes a new declination while the block
// is empty, and the phases cycle through four patterns of sender gaps and
// receiver stalls.
module compass_heading_atan2_test;

    // STAGES mirrors the parameter the block is built with below; FRAC is
    // the block's fixed fraction width.
    localparam int STAGES          = 16;
    localparam int FRAC            = chd_pkg::ANGLE_FRAC_BITS;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    // Cycles with no transfer on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Quiet time at the end, comfortably above the pipeline latency.
    localparam int SETTLE_CYCLES   = 40;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_mode_t;

    // Holds the current declination, predicts the heading for every accepted
    // sample and compares each heading that leaves the block with the oldest
    // prediction.
    class heading_scoreboard;
        logic signed [chd_pkg::DEC_W-1:0] declination;
        logic [chd_pkg::HEAD_W-1:0]       expected_headings[$];
        int unsigned                      mismatches;

        function new();
            declination = chd_pkg::DEC_RESET;
            mismatches  = 0;
        endfunction

        // Vectoring CORDIC on the prescaled axes. The result is the heading
        // after rounding, declination, wrap and clamp.
        function logic [chd_pkg::HEAD_W-1:0] predict_heading(logic [15:0] x_raw,
                                                             logic [15:0] y_raw);
            longint x;
            longint y;
            longint angle;
            longint x_shift;
            longint y_shift;
            longint rounded;
            longint dec;
            longint heading;
            longint full_turn;
            longint half_turn;

            x         = longint'($signed(x_raw));
            y         = longint'($signed(y_raw));
            angle     = 0;
            full_turn = longint'(360) << FRAC;
            half_turn = longint'(180) << FRAC;
            if (x != 0 || y != 0) begin
                // A vector in the left half plane is turned by 180 degrees first.
                if (x < 0) begin
                    angle = (y >= 0) ? longint'(chd_pkg::Z_180) : -longint'(chd_pkg::Z_180);
                    x     = -x;
                    y     = -y;
                end
                x = x << chd_pkg::PRESCALE_SHIFT;
                y = y << chd_pkg::PRESCALE_SHIFT;
                for (int i = 0; i < STAGES && i < chd_pkg::TABLE_LEN; i++) begin
                    x_shift = x >>> i;
                    y_shift = y >>> i;
                    if (y > 0) begin
                        x     = x + y_shift;
                        y     = y - x_shift;
                        angle = angle + longint'(chd_pkg::ATAN_TABLE[i]);
                    end else begin
                        x     = x - y_shift;
                        y     = y + x_shift;
                        angle = angle - longint'(chd_pkg::ATAN_TABLE[i]);
                    end
                end
            end
            // Round half up to the output fraction width.
            rounded = (angle + (longint'(1) << (chd_pkg::ZFRAC - FRAC - 1)))
                      >>> (chd_pkg::ZFRAC - FRAC);
            // The register may hold more than +/-180 degrees; it saturates.
            dec = longint'(declination);
            if (dec > half_turn) begin
                dec = half_turn;
            end
            if (dec < -half_turn) begin
                dec = -half_turn;
            end
            heading = rounded + dec;
            if (heading > full_turn) begin
                heading = heading - full_turn;
            end
            if (heading < 0) begin
                heading = heading + full_turn;
            end
            if (heading < 0) begin
                heading = 0;
            end
            if (heading > full_turn) begin
                heading = full_turn;
            end
            return heading[chd_pkg::HEAD_W-1:0];
        endfunction

        function void note_sample(logic [15:0] x_raw, logic [15:0] y_raw);
            expected_headings.push_back(predict_heading(x_raw, y_raw));
        endfunction

        function int pending();
            return expected_headings.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_heading(logic [chd_pkg::HEAD_W-1:0] got);
            logic [chd_pkg::HEAD_W-1:0] want;
            if (expected_headings.size() == 0) begin
                report_mismatch($sformatf("heading %0d with no sample outstanding", got));
            end else begin
                want = expected_headings.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("heading_degrees got %0d, expected %0d",
                                              got, want));
                end
            end
        endtask
    endclass

    // Every input has a known value from time zero.
    logic                               aclk        = 1'b0;
    logic                               aresetn     = 1'b0;
    logic                               cfg_wr_en   = 1'b0;
    logic [chd_pkg::DEC_W-1:0]          cfg_wr_data = '0;
    logic                               s_tvalid    = 1'b0;
    logic [chd_pkg::S_TDATA_W-1:0]      s_tdata     = '0;   // x_raw_word, y_raw_word
    logic                               m_tready    = 1'b0;
    logic                               s_tready;
    logic                               m_tvalid;
    logic [chd_pkg::M_TDATA_W-1:0]      m_tdata;            // heading_degrees, zero pad

    int unsigned                        send_idle_pct = 0;
    int unsigned                        stall_pct     = 0;
    int unsigned                        quiet_cycles  = 0;
    heading_scoreboard                  headings;

    compass_heading_atan2 #(
        .CORDIC_STAGES  (STAGES)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver decides afresh at every edge whether it takes a heading.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Output monitor. Values sampled here are the ones from before the edge,
    // so a transfer is seen exactly as the block sees it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            headings.check_heading(m_tdata[chd_pkg::HEAD_W-1:0]);
        end
    end

    // The watchdog restarts whenever either channel completes a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_traffic(traffic_mode_t mode);
        case (mode)
            TRAFFIC_STEADY: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            TRAFFIC_SENDER_GAPS: begin
                send_idle_pct = 66;
                stall_pct     = 0;
            end
            TRAFFIC_RECEIVER_STALLS: begin
                send_idle_pct = 0;
                stall_pct     = 66;
            end
            default: begin
                send_idle_pct = 33;
                stall_pct     = 33;
            end
        endcase
    endtask

    // Offers one sample and returns at the edge where it is accepted. Valid is
    // left high so that a following sample can go out back to back. It is
    // lowered only when a gap is chosen or the stream pauses.
    task automatic send_sample(logic [15:0] x_word, logic [15:0] y_word);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y_word, x_word};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        headings.note_sample(x_word, y_word);
    endtask

    // Stops the sample stream until every predicted heading has come back.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (headings.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One write to the declination register. This is only called with the
    // pipeline empty, since every sample yields a heading.
    task automatic write_declination(logic [chd_pkg::DEC_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        headings.declination = value;
    endtask

    // Axis values are weighted toward the corners of the CORDIC: tiny vectors,
    // full scale, and the most negative word, which has no positive twin.
    function automatic logic [15:0] random_axis();
        logic [15:0] magnitude;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                return 16'($urandom);
            end
            5, 6: begin
                magnitude = 16'($urandom_range(16));
                return $urandom_range(1) ? -magnitude : magnitude;
            end
            7: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default: begin
                magnitude = 16'($urandom_range(255));
                return $urandom_range(1) ? 16'h8000 + magnitude : 16'h7FFF - magnitude;
            end
        endcase
    endfunction

    // Some pairs lie on the axes or the diagonals, where CORDIC decisions
    // sit right at y = 0 and the half-plane turn matters most.
    task automatic send_random_sample();
        logic [15:0] x_word;
        logic [15:0] y_word;
        x_word = random_axis();
        case ($urandom_range(9))
            0:       y_word = x_word;
            1:       y_word = -x_word;
            2:       y_word = 16'h0000;
            default: y_word = random_axis();
        endcase
        send_sample(x_word, y_word);
    endtask

    initial begin
        // Directed samples as {y, x}: the zero vector, the axis and corner
        // extremes, negative X with Y on either side of zero, and unit steps.
        logic [31:0] directed_samples [20];
        logic [chd_pkg::DEC_W-1:0] dec_value;

        directed_samples = '{
            {16'h0000, 16'h0000}, {16'h0000, 16'h7FFF}, {16'h0000, 16'h8000},
            {16'h7FFF, 16'h0000}, {16'h8000, 16'h0000}, {16'h8000, 16'h8000},
            {16'h7FFF, 16'h7FFF}, {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000},
            {16'h0000, 16'hFFFF}, {16'hFFFF, 16'hFFFF}, {16'h0001, 16'hFFFF},
            {16'h0000, 16'h0001}, {16'h0001, 16'h0000}, {16'hFFFF, 16'h0000},
            {16'hFFFF, 16'h0001}, {16'hAAAA, 16'h5555}, {16'h5555, 16'hAAAA},
            {16'h0064, 16'h0064}, {16'h0064, 16'hFF9C}
        };
        headings = new();
        set_traffic(TRAFFIC_STEADY);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The directed part runs under the declination left by reset.
        foreach (directed_samples[i]) begin
            send_sample(directed_samples[i][15:0], directed_samples[i][31:16]);
        end
        wait_until_drained();

        for (int phase = 1; phase <= PHASES; phase++) begin
            // Declinations cover both limits of the legal range and the 17-bit
            // extremes, which must saturate, as well as zero and random values.
            case (phase)
                1:       dec_value = 17'sd46080;
                2:       dec_value = -17'sd46080;
                3:       dec_value = 17'h0FFFF;
                4:       dec_value = 17'h10000;
                5:       dec_value = '0;
                6:       dec_value = 17'($urandom_range(92160) - 46080);
                7:       dec_value = 17'sd23040;
                default: dec_value = 17'($urandom);
            endcase
            write_declination(dec_value);
            set_traffic(traffic_mode_t'((phase - 1) % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through every other phase the stream pauses until
                // the pipeline is empty again and then refills from cold.
                if (phase % 2 == 0 && n == ITEMS_PER_PHASE / 2) begin
                    wait_until_drained();
                end
                send_random_sample();
            end
            wait_until_drained();
        end

        // Nothing is outstanding now. Any heading that still appears is an
        // error, so the run waits a little longer before it ends.
        set_traffic(TRAFFIC_STEADY);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (headings.mismatches == 0 && headings.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/chd_pkg.sv
rtl/core/compass_heading_atan2.sv
sim/compass_heading_atan2_test.sv
